@@ rtl/dvt_pkg.sv @@
// Shared constants and item codes for the distance-vector table update block.
`default_nettype none

package dvt_pkg;

  // Fixed field widths of the item channels
  localparam int DEST_W = 6;
  localparam int HOP_W  = 6;
  localparam int PORT_W = 4;
  localparam int OP_W   = 1;

  // Defaults for the top-level parameters
  localparam int NODES_DEFAULT     = 64;
  localparam int COST_BITS_DEFAULT = 24;

  // Item codes
  localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
  localparam logic [OP_W-1:0] OP_ADVERT = 1'b1;

endpackage

`default_nettype wire

@@ rtl/dvt_update.sv @@
// Route entry update: load or one Bellman-Ford relaxation with a saturating cost sum.
`default_nettype none

module dvt_update #(
  parameter int COST_BITS = dvt_pkg::COST_BITS_DEFAULT
) (
  input  wire logic [dvt_pkg::OP_W-1:0]   opcode,
  input  wire logic [COST_BITS-1:0]       cost_value,
  input  wire logic [dvt_pkg::HOP_W-1:0]  neighbor_id,
  input  wire logic [dvt_pkg::PORT_W-1:0] port_index,
  input  wire logic                       port_valid,
  input  wire logic [COST_BITS-1:0]       link_cost,
  input  wire logic [COST_BITS-1:0]       cur_cost,
  input  wire logic [dvt_pkg::HOP_W-1:0]  cur_hop,
  input  wire logic [dvt_pkg::PORT_W-1:0] cur_port,
  output logic      [COST_BITS-1:0]       new_cost,
  output logic      [dvt_pkg::HOP_W-1:0]  new_hop,
  output logic      [dvt_pkg::PORT_W-1:0] new_port,
  output logic                            changed
);

  logic [COST_BITS:0]   sum_wide;
  logic [COST_BITS-1:0] sum;

  assign sum_wide = {1'b0, link_cost} + {1'b0, cost_value};
  // saturate at the unreachable code
  assign sum = sum_wide[COST_BITS] ? {COST_BITS{1'b1}} : sum_wide[COST_BITS-1:0];

  always_comb begin
    new_cost = cur_cost;
    new_hop  = cur_hop;
    new_port = cur_port;
    changed  = 1'b0;
    case (opcode)
      dvt_pkg::OP_LOAD: begin
        new_cost = cost_value;
        new_hop  = neighbor_id;
        new_port = port_index;
        changed  = (cur_cost != cost_value) || (cur_hop != neighbor_id) ||
                   (cur_port != port_index);
      end
      dvt_pkg::OP_ADVERT: begin
        if (port_valid) begin
          if (cur_hop == neighbor_id) begin
            // already routed via this neighbour: follow its cost either way
            new_cost = sum;
            changed  = (cur_cost != sum);
          end else if (cur_cost > sum) begin
            new_cost = sum;
            new_hop  = neighbor_id;
            new_port = port_index;
            changed  = 1'b1;
          end
        end
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/distance_vector_table_update.sv @@
// Distance-vector routing table: route store, read-modify-write pipeline and result register.
//
// Input channel in_valid/in_ready carries load items (opcode load) that write one
// route entry, and advertisement elements that relax one entry against a
// neighbour's advertised cost plus its link cost. Each item gives exactly one
// result on out_valid/out_ready: the addressed entry after the item, its change
// flag, and on the last element of an advertisement the round's sticky change flag.
// The item is registered into the update stage on the input transfer, and the result
// register and out_valid load when the update stage advances. Throughput:
// one item per cycle while out_ready is high; the route store is read on the
// transfer edge and written when the update stage advances, with the last write
// forwarded so that back-to-back items to the same entry see fresh data.
// Reset: after rst the block sweeps the route store, one entry per cycle, to
// unreachable cost with zero next hop and port; in_ready stays low while the
// sweep runs.
// Stall: while out_ready is low a held result keeps one item waiting in the
// pipeline; in_ready drops until the result is transferred.
`default_nettype none

module distance_vector_table_update #(
  parameter int NODES     = dvt_pkg::NODES_DEFAULT,
  parameter int COST_BITS = dvt_pkg::COST_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dvt_pkg::OP_W-1:0]   opcode,
  input  wire logic [dvt_pkg::DEST_W-1:0] dest_index,
  input  wire logic [COST_BITS-1:0]       cost_value,
  input  wire logic [dvt_pkg::HOP_W-1:0]  neighbor_id,
  input  wire logic [dvt_pkg::PORT_W-1:0] port_index,
  input  wire logic                       port_valid,
  input  wire logic [COST_BITS-1:0]       link_cost,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [COST_BITS-1:0]       entry_cost,
  output logic      [dvt_pkg::HOP_W-1:0]  entry_next_hop,
  output logic      [dvt_pkg::PORT_W-1:0] entry_port,
  output logic                            entry_changed,
  output logic                            table_changed,
  output logic                            result_last
);

  localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ENTRY_W = COST_BITS + dvt_pkg::HOP_W + dvt_pkg::PORT_W;
  localparam int DEST_N  = 1 << dvt_pkg::DEST_W;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET =
    {{COST_BITS{1'b1}}, {dvt_pkg::HOP_W{1'b0}}, {dvt_pkg::PORT_W{1'b0}}};
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  // destination index reduced to a table address
  logic [IDX_W-1:0] idx_lut [DEST_N];

  for (genvar g = 0; g < DEST_N; g++) begin : g_idx_lut
    assign idx_lut[g] = IDX_W'(g % NODES);
  end

  // route store
  logic [ENTRY_W-1:0] mem [NODES];
  logic [ENTRY_W-1:0] rd_entry;

  // reset sweep
  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  // update stage
  logic                       s1_valid;
  logic [dvt_pkg::OP_W-1:0]   s1_op;
  logic [IDX_W-1:0]           s1_idx;
  logic [COST_BITS-1:0]       s1_cost;
  logic [dvt_pkg::HOP_W-1:0]  s1_nb;
  logic [dvt_pkg::PORT_W-1:0] s1_port;
  logic                       s1_pvalid;
  logic [COST_BITS-1:0]       s1_link;
  logic                       s1_last;

  // last write, for forwarding
  logic               wr_valid;
  logic [IDX_W-1:0]   wr_idx;
  logic [ENTRY_W-1:0] wr_entry;

  logic round_changed;

  logic                       in_xfer;
  logic                       s1_advance;
  logic [ENTRY_W-1:0]         cur_entry;
  logic [COST_BITS-1:0]       new_cost;
  logic [dvt_pkg::HOP_W-1:0]  new_hop;
  logic [dvt_pkg::PORT_W-1:0] new_port;
  logic                       upd_changed;
  logic                       round_next;
  logic                       tch_next;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !clearing && (!s1_valid || s1_advance);
  assign in_xfer    = in_valid && in_ready;

  assign cur_entry = (wr_valid && (wr_idx == s1_idx)) ? wr_entry : rd_entry;

  dvt_update #(
    .COST_BITS (COST_BITS)
  ) u_update (
    .opcode      (s1_op),
    .cost_value  (s1_cost),
    .neighbor_id (s1_nb),
    .port_index  (s1_port),
    .port_valid  (s1_pvalid),
    .link_cost   (s1_link),
    .cur_cost    (cur_entry[ENTRY_W-1 -: COST_BITS]),
    .cur_hop     (cur_entry[dvt_pkg::PORT_W +: dvt_pkg::HOP_W]),
    .cur_port    (cur_entry[dvt_pkg::PORT_W-1:0]),
    .new_cost    (new_cost),
    .new_hop     (new_hop),
    .new_port    (new_port),
    .changed     (upd_changed)
  );

  always_comb begin
    round_next = round_changed;
    tch_next   = 1'b0;
    if (s1_op == dvt_pkg::OP_ADVERT) begin
      tch_next   = s1_last && (round_changed || upd_changed);
      round_next = s1_last ? 1'b0 : (round_changed || upd_changed);
    end
  end

  // store read on transfer, written by the sweep or the update stage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_entry <= mem[idx_lut[dest_index]];
    end
    if (clearing) begin
      mem[clr_addr] <= ENTRY_RESET;
    end else if (s1_advance) begin
      mem[s1_idx] <= {new_cost, new_hop, new_port};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      s1_valid      <= 1'b0;
      wr_valid      <= 1'b0;
      round_changed <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        wr_valid      <= 1'b1;
        round_changed <= round_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op     <= opcode;
      s1_idx    <= idx_lut[dest_index];
      s1_cost   <= cost_value;
      s1_nb     <= neighbor_id;
      s1_port   <= port_index;
      s1_pvalid <= port_valid;
      s1_link   <= link_cost;
      s1_last   <= last;
    end
    if (s1_advance) begin
      wr_idx         <= s1_idx;
      wr_entry       <= {new_cost, new_hop, new_port};
      entry_cost     <= new_cost;
      entry_next_hop <= new_hop;
      entry_port     <= new_port;
      entry_changed  <= upd_changed;
      table_changed  <= tch_next;
      result_last    <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_tch_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_changed) |-> result_last)
    else $error("table_changed raised on a non-last result");

  a_xfer_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("transferred item lost before the update stage");

  a_sweep_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !out_valid))
    else $error("item in flight during the reset sweep");

  a_round_sticky: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && upd_changed && (s1_op == dvt_pkg::OP_ADVERT) && !s1_last)
      |=> round_changed)
    else $error("round change flag not set after an entry change");
`endif

endmodule

`default_nettype wire
